// ===== rtl/shad_pkg.sv =====
// Package for the STUN header and attribute deframer.
// Holds the size limit, phase, kind and status codes, and the channel payload types.
// No dependencies.
`timescale 1ns / 1ps

package shad_pkg;

    localparam int MAX_PACKET_BYTES = 4096;
    localparam int CNT_W            = $clog2(MAX_PACKET_BYTES + 1);

    localparam logic [31:0] STUN_COOKIE = 32'h2112_A442;

    // parser phases
    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_TYPE_HI = 3'd1;
    localparam logic [2:0] PH_TYPE_LO = 3'd2;
    localparam logic [2:0] PH_LEN_HI  = 3'd3;
    localparam logic [2:0] PH_LEN_LO  = 3'd4;
    localparam logic [2:0] PH_VALUE   = 3'd5;
    localparam logic [2:0] PH_PAD     = 3'd6;

    // result kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_ATTR   = 2'd1;
    localparam logic [1:0] KIND_VALUE  = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    // packet status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_TOP_BITS = 3'd1;
    localparam logic [2:0] ST_LENGTH   = 3'd2;
    localparam logic [2:0] ST_COOKIE   = 3'd3;
    localparam logic [2:0] ST_TRUNC    = 3'd4;
    localparam logic [2:0] ST_OVERSIZE = 3'd5;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] msg_method;
        logic [1:0]  msg_class;
        logic [15:0] msg_length;
        logic [31:0] txid_upper;
        logic [63:0] txid_lower;
        logic [15:0] attr_kind;
        logic [15:0] attr_len;
        logic [11:0] value_offset;
        logic [7:0]  value_byte;
        logic [2:0]  status;
        logic        last_of_run;
    } t_result;

endpackage

// ===== rtl/shad_if.sv =====
// Valid/ready channel interfaces for the STUN deframer: byte input and result output.
// Depends on shad_pkg for the payload types.
`timescale 1ns / 1ps

interface shad_in_if import shad_pkg::*; ();
    logic  valid;
    logic  ready;
    t_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface shad_out_if import shad_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/stun_header_attribute_deframer.sv =====
// STUN header and attribute deframer, top level.
// Depends on shad_pkg and the channel interfaces in shad_if.sv.
`timescale 1ns / 1ps

// Takes one packet byte per transfer, with last_byte on the final byte, checks the
// 20-byte header (top bits, length multiple of 4, magic cookie), emits a header
// result, then one start result per attribute and one result per value byte, and
// closes each packet with a status result flagged last_of_run. Padding is skipped;
// after an error the rest of the packet is dropped. One byte is taken every cycle
// while the holding slot is empty and the output register is free or being read,
// and its results leave from the output register. A byte that yields two results
// (a final byte that also completes the header, an attribute start or a value)
// parks the status in a holding register, and input pauses while it drains.
// Throughput is set by the single output register plus one holding slot.
module stun_header_attribute_deframer
    import shad_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    shad_in_if.sink    i_in,
    shad_out_if.source o_out
);

    // parser state
    logic [CNT_W-1:0] r_count, n_count;
    logic [2:0]       r_phase, n_phase;
    logic             r_error, n_error;
    logic [11:0]      r_method, n_method;
    logic [1:0]       r_class, n_class;
    logic [15:0]      r_length, n_length;
    logic [31:0]      r_cookie, n_cookie;
    logic [31:0]      r_txid_hi, n_txid_hi;
    logic [63:0]      r_txid_lo, n_txid_lo;
    logic [15:0]      r_attr_type, n_attr_type;
    logic [15:0]      r_remaining, n_remaining;
    logic [1:0]       r_pad_left, n_pad_left;

    // output register and holding slot
    t_result r_out, r_pend;
    logic    r_out_valid, r_pend_valid;

    t_result    res0, res1;
    logic       v0, v1;
    logic [2:0] err;
    logic [CNT_W:0] pos_inc;
    logic [15:0] len_word;
    logic [7:0]  b;
    logic        last;
    logic        in_fire, out_fire;

    assign b        = i_in.data.byte_in;
    assign last     = i_in.data.last_byte;
    assign pos_inc  = {1'b0, r_count} + 1'b1;
    assign len_word = {r_remaining[15:8], b};

    assign i_in.ready  = !r_pend_valid && (!r_out_valid || o_out.ready);
    assign in_fire     = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
    assign out_fire    = r_out_valid && o_out.ready;

    always_comb begin
        n_count     = r_count;
        n_phase     = r_phase;
        n_error     = r_error;
        n_method    = r_method;
        n_class     = r_class;
        n_length    = r_length;
        n_cookie    = r_cookie;
        n_txid_hi   = r_txid_hi;
        n_txid_lo   = r_txid_lo;
        n_attr_type = r_attr_type;
        n_remaining = r_remaining;
        n_pad_left  = r_pad_left;
        res0        = '0;
        res1        = '0;
        v0          = 1'b0;
        v1          = 1'b0;
        err         = ST_OK;

        if (r_error) begin
            // drop the rest of a failed packet
            if (last) begin
                n_count     = '0;
                n_phase     = PH_HEADER;
                n_remaining = '0;
                n_pad_left  = '0;
                n_error     = 1'b0;
            end
        end else if (r_count >= CNT_W'(MAX_PACKET_BYTES)) begin
            res0.kind        = KIND_STATUS;
            res0.status      = ST_OVERSIZE;
            res0.last_of_run = 1'b1;
            v0               = 1'b1;
            if (last) begin
                n_count     = '0;
                n_phase     = PH_HEADER;
                n_remaining = '0;
                n_pad_left  = '0;
                n_error     = 1'b0;
            end else begin
                n_error = 1'b1;
            end
        end else begin
            n_count = CNT_W'(pos_inc);
            unique case (r_phase)
                PH_HEADER: begin
                    if (r_count == CNT_W'(0)) begin
                        if (b[7:6] != 2'b00) begin
                            err = ST_TOP_BITS;
                        end else begin
                            n_method = {b[5:1], 7'd0};
                            n_class  = {b[0], 1'b0};
                        end
                    end else if (r_count == CNT_W'(1)) begin
                        n_method = {r_method[11:7], b[7:5], b[3:0]};
                        n_class  = {r_class[1], b[4]};
                    end else if (r_count < CNT_W'(4)) begin
                        n_length = {r_length[7:0], b};
                        if (r_count == CNT_W'(3) && b[1:0] != 2'b00) begin
                            err = ST_LENGTH;
                        end
                    end else if (r_count < CNT_W'(8)) begin
                        n_cookie = {r_cookie[23:0], b};
                        if (r_count == CNT_W'(7) && {r_cookie[23:0], b} != STUN_COOKIE) begin
                            err = ST_COOKIE;
                        end
                    end else if (r_count < CNT_W'(12)) begin
                        n_txid_hi = {r_txid_hi[23:0], b};
                    end else begin
                        n_txid_lo = {r_txid_lo[55:0], b};
                        if (r_count == CNT_W'(19)) begin
                            res0.kind       = KIND_HEADER;
                            res0.msg_method = r_method;
                            res0.msg_class  = r_class;
                            res0.msg_length = r_length;
                            res0.txid_upper = r_txid_hi;
                            res0.txid_lower = {r_txid_lo[55:0], b};
                            v0              = 1'b1;
                            n_phase         = PH_TYPE_HI;
                        end
                    end
                end
                PH_TYPE_LO: begin
                    n_attr_type = {r_attr_type[15:8], b};
                    n_phase     = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_remaining = {b, 8'd0};
                    n_phase     = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_remaining       = len_word;
                    res0.kind         = KIND_ATTR;
                    res0.attr_kind    = r_attr_type;
                    res0.attr_len     = len_word;
                    res0.value_offset = 12'(pos_inc);
                    v0                = 1'b1;
                    n_pad_left        = 2'(2'd0 - len_word[1:0]);
                    n_phase           = (len_word != 16'd0) ? PH_VALUE : PH_TYPE_HI;
                end
                PH_VALUE: begin
                    res0.kind       = KIND_VALUE;
                    res0.value_byte = b;
                    v0              = 1'b1;
                    n_remaining     = r_remaining - 16'd1;
                    if (r_remaining == 16'd1) begin
                        n_phase = (r_pad_left != 2'd0) ? PH_PAD : PH_TYPE_HI;
                    end
                end
                PH_PAD: begin
                    n_pad_left = r_pad_left - 2'd1;
                    if (r_pad_left == 2'd1) begin
                        n_phase = PH_TYPE_HI;
                    end
                end
                default: begin
                    n_attr_type = {b, 8'd0};
                    n_phase     = PH_TYPE_LO;
                end
            endcase

            if (err != ST_OK) begin
                res0             = '0;
                res0.kind        = KIND_STATUS;
                res0.status      = err;
                res0.last_of_run = 1'b1;
                v0               = 1'b1;
                if (last) begin
                    n_count     = '0;
                    n_phase     = PH_HEADER;
                    n_remaining = '0;
                    n_pad_left  = '0;
                    n_error     = 1'b0;
                end else begin
                    n_error = 1'b1;
                end
            end else if (last) begin
                // close the packet: ok only on an attribute boundary
                if (v0) begin
                    res1.kind        = KIND_STATUS;
                    res1.status      = (n_phase == PH_TYPE_HI) ? ST_OK : ST_TRUNC;
                    res1.last_of_run = 1'b1;
                    v1               = 1'b1;
                end else begin
                    res0.kind        = KIND_STATUS;
                    res0.status      = (n_phase == PH_TYPE_HI) ? ST_OK : ST_TRUNC;
                    res0.last_of_run = 1'b1;
                    v0               = 1'b1;
                end
                n_count     = '0;
                n_phase     = PH_HEADER;
                n_remaining = '0;
                n_pad_left  = '0;
                n_error     = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_phase      <= PH_HEADER;
            r_error      <= 1'b0;
            r_remaining  <= '0;
            r_pad_left   <= '0;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_count      <= n_count;
                r_phase      <= n_phase;
                r_error      <= n_error;
                r_remaining  <= n_remaining;
                r_pad_left   <= n_pad_left;
                r_out_valid  <= v0;
                r_pend_valid <= v1;
            end else if (out_fire) begin
                // advance the held status into the output register
                r_out_valid  <= r_pend_valid;
                r_pend_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_method    <= n_method;
            r_class     <= n_class;
            r_length    <= n_length;
            r_cookie    <= n_cookie;
            r_txid_hi   <= n_txid_hi;
            r_txid_lo   <= n_txid_lo;
            r_attr_type <= n_attr_type;
            r_out       <= res0;
            r_pend      <= res1;
        end else if (out_fire) begin
            r_out <= r_pend;
        end
    end

endmodule

// ===== dv/tb_stun_header_attribute_deframer.sv =====
`timescale 1ns / 1ps
// Testbench for stun_header_attribute_deframer: streams STUN packets byte by byte,
// predicts each result and checks every one of them in order.
// Depends on shad_pkg and the channel interfaces in shad_if.sv.

module tb_stun_header_attribute_deframer
    import shad_pkg::*;
();

    localparam int HALF_PERIOD     = 4;
    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int DRAIN_CYCLES    = 20;
    localparam int BYTES_PER_PHASE = 340;
    localparam int MAX_REPORTS     = 40;

    logic i_clk;
    logic i_rst_n;

    shad_in_if  in_if ();
    shad_out_if out_if ();

    stun_header_attribute_deframer dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    t_item      pending_bytes[$];
    t_result    expected_results[$];
    logic [7:0] pkt[$];
    t_result    got_res;
    t_result    want_res;

    int bytes_queued;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_req_cnt;
    int hold_ack_cnt;
    int hold_left;
    int mismatch_count;
    int stall_cycles;

    // parser state mirrored from the block
    logic [CNT_W-1:0] p_count;
    logic [2:0]       p_phase;
    logic [11:0]      p_method;
    logic [1:0]       p_class;
    logic [15:0]      p_length;
    logic [31:0]      p_cookie;
    logic [31:0]      p_txid_hi;
    logic [63:0]      p_txid_lo;
    logic [15:0]      p_attr_type;
    logic [15:0]      p_remaining;
    logic [1:0]       p_pad;
    logic             p_error_seen;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // append helpers for the packet buffer and the two work queues
    function automatic void add_byte(logic [7:0] v);
        pkt.insert(pkt.size(), v);
    endfunction

    function automatic void queue_result(t_result r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic void queue_item(t_item it);
        pending_bytes.insert(pending_bytes.size(), it);
    endfunction

    function automatic void end_of_packet();
        p_count      = '0;
        p_phase      = PH_HEADER;
        p_remaining  = '0;
        p_pad        = '0;
        p_error_seen = 1'b0;
    endfunction

    function automatic void push_status(logic [2:0] code);
        t_result r;
        r             = '0;
        r.kind        = KIND_STATUS;
        r.status      = code;
        r.last_of_run = 1'b1;
        queue_result(r);
    endfunction

    function automatic void deframe_byte(t_item it);
        logic [7:0]       b;
        logic [CNT_W-1:0] pos;
        logic [2:0]       err;
        t_result          r;
        b   = it.byte_in;
        err = ST_OK;
        r   = '0;
        if (p_error_seen) begin
            if (it.last_byte)
                end_of_packet();
            return;
        end
        if (p_count >= MAX_PACKET_BYTES) begin
            push_status(ST_OVERSIZE);
            if (it.last_byte)
                end_of_packet();
            else
                p_error_seen = 1'b1;
            return;
        end
        pos     = p_count;
        p_count = p_count + 1'b1;
        case (p_phase)
            PH_HEADER: begin
                if (pos == 0) begin
                    if (b[7:6] != 2'b00) begin
                        err = ST_TOP_BITS;
                    end else begin
                        p_method = {b[5:1], 7'd0};
                        p_class  = {b[0], 1'b0};
                    end
                end else if (pos == 1) begin
                    // type bits interleave the class between method slices
                    p_method[6:4] = b[7:5];
                    p_method[3:0] = b[3:0];
                    p_class[0]    = b[4];
                end else if (pos < 4) begin
                    p_length = {p_length[7:0], b};
                    if (pos == 3 && p_length[1:0] != 2'b00)
                        err = ST_LENGTH;
                end else if (pos < 8) begin
                    p_cookie = {p_cookie[23:0], b};
                    if (pos == 7 && p_cookie != STUN_COOKIE)
                        err = ST_COOKIE;
                end else if (pos < 12) begin
                    p_txid_hi = {p_txid_hi[23:0], b};
                end else begin
                    p_txid_lo = {p_txid_lo[55:0], b};
                    if (pos == 19) begin
                        r.kind       = KIND_HEADER;
                        r.msg_method = p_method;
                        r.msg_class  = p_class;
                        r.msg_length = p_length;
                        r.txid_upper = p_txid_hi;
                        r.txid_lower = p_txid_lo;
                        queue_result(r);
                        p_phase = PH_TYPE_HI;
                    end
                end
            end
            PH_TYPE_LO: begin
                p_attr_type[7:0] = b;
                p_phase          = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                p_remaining = {b, 8'h00};
                p_phase     = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                p_remaining[7:0] = b;
                r.kind           = KIND_ATTR;
                r.attr_kind      = p_attr_type;
                r.attr_len       = p_remaining;
                r.value_offset   = 12'(pos + 1'b1);
                queue_result(r);
                p_pad   = 2'(3'd4 - {1'b0, p_remaining[1:0]});
                p_phase = (p_remaining != 0) ? PH_VALUE : PH_TYPE_HI;
            end
            PH_VALUE: begin
                r.kind       = KIND_VALUE;
                r.value_byte = b;
                queue_result(r);
                p_remaining = p_remaining - 1'b1;
                if (p_remaining == 0)
                    p_phase = (p_pad != 0) ? PH_PAD : PH_TYPE_HI;
            end
            PH_PAD: begin
                p_pad = p_pad - 1'b1;
                if (p_pad == 0)
                    p_phase = PH_TYPE_HI;
            end
            default: begin
                p_attr_type = {b, 8'h00};
                p_phase     = PH_TYPE_LO;
            end
        endcase
        if (err != ST_OK) begin
            push_status(err);
            if (it.last_byte)
                end_of_packet();
            else
                p_error_seen = 1'b1;
        end else if (it.last_byte) begin
            push_status((p_phase == PH_TYPE_HI) ? ST_OK : ST_TRUNC);
            end_of_packet();
        end
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (mismatch_count < MAX_REPORTS)
            $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // packet assembly into pkt
    task automatic add_header(logic [15:0] mtype, logic [15:0] mlen, logic [31:0] cookie,
                              logic [95:0] txid);
        add_byte(mtype[15:8]);
        add_byte(mtype[7:0]);
        add_byte(mlen[15:8]);
        add_byte(mlen[7:0]);
        for (int i = 3; i >= 0; i--)
            add_byte(cookie[i*8 +: 8]);
        for (int i = 11; i >= 0; i--)
            add_byte(txid[i*8 +: 8]);
    endtask

    task automatic add_attr(logic [15:0] atype, logic [15:0] alen, int nvalue);
        int pad;
        add_byte(atype[15:8]);
        add_byte(atype[7:0]);
        add_byte(alen[15:8]);
        add_byte(alen[7:0]);
        for (int i = 0; i < nvalue; i++)
            add_byte(8'($urandom));
        pad = (4 - int'(alen[1:0])) % 4;
        if (nvalue == int'(alen))
            for (int i = 0; i < pad; i++)
                add_byte(8'($urandom));
    endtask

    // queue the first keep bytes, flag the final one, and clear the buffer
    task automatic ship_packet(int keep);
        t_item it;
        for (int i = 0; i < keep; i++) begin
            it.byte_in   = pkt[i];
            it.last_byte = (i == keep - 1);
            queue_item(it);
        end
        bytes_queued += keep;
        pkt.delete();
    endtask

    function automatic logic [95:0] random_txid();
        return {$urandom, $urandom, $urandom};
    endfunction

    task automatic directed_packets();
        add_header(16'h0001, 16'h0000, STUN_COOKIE, '1);
        ship_packet(pkt.size());
        // last byte also completes a zero-length attribute
        add_header(16'h3FFF, 16'hFFFC, STUN_COOKIE, '0);
        add_attr(16'hFFFF, 16'h0000, 0);
        ship_packet(pkt.size());
        add_header(16'h0111, 16'd24, STUN_COOKIE, random_txid());
        add_attr(16'h0001, 16'd1, 1);
        add_attr(16'h8022, 16'd4, 4);
        add_attr(16'h0020, 16'd3, 3);
        ship_packet(pkt.size());
        // stop on the last value byte, ahead of its padding
        add_header(16'h0101, 16'd8, STUN_COOKIE, random_txid());
        add_attr(16'h0020, 16'd3, 3);
        ship_packet(pkt.size() - 1);
        add_header(16'h0002, 16'd8, STUN_COOKIE, random_txid());
        add_attr(16'h0006, 16'd4, 4);
        ship_packet(pkt.size());
        add_header(16'h0001, 16'd8, STUN_COOKIE, random_txid());
        add_attr(16'h0009, 16'hFFFF, 5);
        ship_packet(pkt.size());
        add_header(16'h8001, 16'd0, STUN_COOKIE, random_txid());
        ship_packet(8);
        add_byte(8'hC0);
        ship_packet(1);
        add_header(16'h4001, 16'd0, STUN_COOKIE, random_txid());
        ship_packet(pkt.size());
        add_header(16'h0001, 16'h0003, STUN_COOKIE, random_txid());
        ship_packet(10);
        add_header(16'h0001, 16'h0002, STUN_COOKIE, random_txid());
        ship_packet(4);
        add_header(16'h0001, 16'd0, 32'h2112_A443, random_txid());
        ship_packet(8);
        add_header(16'h0001, 16'd8, 32'hA442_2112, random_txid());
        add_attr(16'h0001, 16'd4, 4);
        ship_packet(pkt.size());
        // truncation inside header, attribute header, value and padding
        add_header(16'h0001, 16'd0, STUN_COOKIE, random_txid());
        ship_packet(10);
        add_header(16'h0001, 16'd8, STUN_COOKIE, random_txid());
        add_attr(16'h0001, 16'd4, 4);
        ship_packet(22);
        add_header(16'h0001, 16'd12, STUN_COOKIE, random_txid());
        add_attr(16'h0001, 16'd8, 8);
        ship_packet(26);
        add_header(16'h0001, 16'd12, STUN_COOKIE, random_txid());
        add_attr(16'h0001, 16'd5, 5);
        ship_packet(pkt.size() - 2);
        add_byte(8'h00);
        ship_packet(1);
        add_header(16'h0001, 16'd12, STUN_COOKIE, random_txid());
        add_attr(16'h0003, 16'd0, 0);
        add_attr(16'h0004, 16'd2, 2);
        ship_packet(pkt.size());
    endtask

    // one packet ends exactly on the first byte past the size limit, the other later
    task automatic oversize_packets();
        add_header(16'h0001, 16'hFFFC, STUN_COOKIE, random_txid());
        add_attr(16'h0013, 16'hFFFF, MAX_PACKET_BYTES - 23);
        ship_packet(pkt.size());
        add_header(16'h0001, 16'hFFFC, STUN_COOKIE, random_txid());
        add_attr(16'h0013, 16'hFFFF, MAX_PACKET_BYTES - 21);
        ship_packet(pkt.size());
    endtask

    task automatic random_packet();
        int          pick;
        int          n_attr;
        int          alen;
        int          keep;
        logic [15:0] body;
        logic [7:0]  patch;
        pick = $urandom_range(99);
        add_header({2'b00, 14'($urandom)}, 16'($urandom) & 16'hFFFC, STUN_COOKIE,
                   random_txid());
        n_attr = (pick >= 95) ? 0 : $urandom_range(4);
        for (int i = 0; i < n_attr; i++) begin
            alen = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(12);
            add_attr(16'($urandom), 16'(alen), alen);
        end
        if ($urandom_range(1) == 1) begin
            body   = 16'(pkt.size() - 20);
            pkt[2] = body[15:8];
            pkt[3] = body[7:0];
        end
        if (pick < 60 || pick >= 95) begin
            keep = pkt.size();
        end else if (pick < 75) begin
            keep = $urandom_range(pkt.size() - 1, 1);
        end else if (pick < 80) begin
            patch  = pkt[0];
            patch  = {2'($urandom_range(3, 1)), patch[5:0]};
            pkt[0] = patch;
            keep   = $urandom_range(pkt.size(), 1);
        end else if (pick < 85) begin
            patch  = pkt[3];
            patch  = {patch[7:2], 2'($urandom_range(3, 1))};
            pkt[3] = patch;
            keep   = $urandom_range(pkt.size(), 4);
        end else if (pick < 90) begin
            keep      = 4 + $urandom_range(3);
            pkt[keep] = pkt[keep] ^ 8'($urandom_range(255, 1));
            keep      = $urandom_range(pkt.size(), 8);
        end else begin
            pkt.delete();
            keep = $urandom_range(30, 1);
            for (int i = 0; i < keep; i++)
                add_byte(8'($urandom));
        end
        ship_packet(keep);
    endtask

    task automatic random_traffic(int target);
        int start;
        start = bytes_queued;
        while (bytes_queued - start < target)
            random_packet();
    endtask

    // hold off until every byte is taken and every result has come back
    task automatic drain();
        while (pending_bytes.size() != 0 || in_if.valid)
            @(negedge i_clk);
        while (expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    // byte sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_if.data  <= '0;
        end else begin
            if (in_if.valid && in_if.ready)
                deframe_byte(in_if.data);
            if (!in_if.valid || in_if.ready) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_if.valid <= 1'b1;
                    in_if.data  <= pending_bytes.pop_front();
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // result receiver, with a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            hold_left = 0;
        end else begin
            if (hold_ack_cnt != hold_req_cnt) begin
                hold_ack_cnt = hold_req_cnt;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got_res = out_if.data;
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, kind", got_res.kind, '0);
            end else begin
                want_res = expected_results.pop_front();
                if (got_res.kind !== want_res.kind)
                    report_mismatch("kind", got_res.kind, want_res.kind);
                if (got_res.msg_method !== want_res.msg_method)
                    report_mismatch("msg_method", got_res.msg_method, want_res.msg_method);
                if (got_res.msg_class !== want_res.msg_class)
                    report_mismatch("msg_class", got_res.msg_class, want_res.msg_class);
                if (got_res.msg_length !== want_res.msg_length)
                    report_mismatch("msg_length", got_res.msg_length, want_res.msg_length);
                if (got_res.txid_upper !== want_res.txid_upper)
                    report_mismatch("txid_upper", got_res.txid_upper, want_res.txid_upper);
                if (got_res.txid_lower !== want_res.txid_lower)
                    report_mismatch("txid_lower", got_res.txid_lower, want_res.txid_lower);
                if (got_res.attr_kind !== want_res.attr_kind)
                    report_mismatch("attr_kind", got_res.attr_kind, want_res.attr_kind);
                if (got_res.attr_len !== want_res.attr_len)
                    report_mismatch("attr_len", got_res.attr_len, want_res.attr_len);
                if (got_res.value_offset !== want_res.value_offset)
                    report_mismatch("value_offset", got_res.value_offset,
                                    want_res.value_offset);
                if (got_res.value_byte !== want_res.value_byte)
                    report_mismatch("value_byte", got_res.value_byte, want_res.value_byte);
                if (got_res.status !== want_res.status)
                    report_mismatch("status", got_res.status, want_res.status);
                if (got_res.last_of_run !== want_res.last_of_run)
                    report_mismatch("last_of_run", got_res.last_of_run, want_res.last_of_run);
            end
        end
    end

    // end the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        in_if.valid    = 1'b0;
        in_if.data     = '0;
        out_if.ready   = 1'b0;
        bytes_queued   = 0;
        hold_req_cnt   = 0;
        hold_ack_cnt   = 0;
        hold_left      = 0;
        mismatch_count = 0;
        stall_cycles   = 0;
        p_method       = '0;
        p_class        = '0;
        p_length       = '0;
        p_cookie       = '0;
        p_txid_hi      = '0;
        p_txid_lo      = '0;
        p_attr_type    = '0;
        end_of_packet();
        send_idle_pct = 28;
        recv_idle_pct = 52;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        directed_packets();
        random_traffic(BYTES_PER_PHASE / 2);
        hold_req_cnt++;
        random_traffic(BYTES_PER_PHASE / 2);
        drain();

        send_idle_pct = 52;
        recv_idle_pct = 28;
        oversize_packets();
        random_traffic(BYTES_PER_PHASE);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_traffic(BYTES_PER_PHASE);
        drain();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/shad_pkg.sv
rtl/shad_if.sv
rtl/stun_header_attribute_deframer.sv
dv/tb_stun_header_attribute_deframer.sv
